>>> rtl/gmsh_pkg.sv
// Package for the gated matrix slice histogrammer.
// Request codes, register indexes, FSM state type and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package gmsh_pkg;

  localparam int NUM_GATES_DEF    = 32;
  localparam int NUM_CHANNELS_DEF = 4096;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_CELL = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [7:0] CFG_SLICE_MODE   = 8'd0;
  localparam logic [7:0] CFG_ACTIVE_GATES = 8'd1;
  localparam logic [7:0] CFG_ADD_ALL      = 8'd2;

  localparam logic [1:0] MODE_X = 2'd0;
  localparam logic [1:0] MODE_Y = 2'd1;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_CELL_CHK,
    ST_CELL_WR,
    ST_RD_CHK,
    ST_RD_ACC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take_req;
    logic load_win;
    logic clr_write;
    logic loop_all;
    logic loop_one;
    logic step_cell;
    logic step_gate;
    logic bump_write;
    logic acc_add;
    logic set_err;
    logic res_load;
    logic sweep_write;
  } dp_cmd_t;

  typedef struct packed {
    logic       gi_inactive;
    logic       ch_out;
    logic       loop_done;
    logic       hit;
    logic       clr_last;
    logic       sweep_last;
    logic       add_all;
    logic [1:0] req_type;
  } dp_sts_t;

endpackage

>>> rtl/gmsh_if.sv
// Channel interfaces of the gated matrix slice histogrammer: request, result, register write.
// No dependencies.
`timescale 1ns / 1ps

interface gmsh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  gate_index;
  logic [11:0] gate_low;
  logic [11:0] gate_high;
  logic [11:0] cell_row;
  logic [11:0] cell_column;
  logic [31:0] cell_count;
  logic [11:0] read_channel;
  modport source (output valid, req_type, gate_index, gate_low, gate_high, cell_row,
                  cell_column, cell_count, read_channel, input ready);
  modport sink (input valid, req_type, gate_index, gate_low, gate_high, cell_row,
                cell_column, cell_count, read_channel, output ready);
endinterface

interface gmsh_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic        status;
  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

interface gmsh_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/gated_matrix_slice_histogrammer.sv
// Top level of the gated matrix slice histogrammer.
// Depends on gmsh_pkg, gmsh_if, gmsh_ctrl and gmsh_datapath.
//
// Channels: req takes one request (load gate, matrix cell, read bin); rsp returns one
// result per request (read_value, status); cfg writes slice_mode, active_gates, add_all
// by index and is always ready. Handshakes complete on valid and ready both high.
// One request is worked at a time; work per request, n = active gates:
//   load:  the gate's NUM_CHANNELS histogram bins cleared, one bin per cycle
//   cell:  n gates, two window checks each, read-modify-write per hit
//   read:  one histogram read per summed gate
// The histogram memory has a separate write port and a registered read port.
// The result sits in an output register; req is taken again as soon as the result
// is loaded, so one result may wait while the next request is worked. A stalled
// receiver holds the result and the block waits before loading another.
// Reset: configuration and loop registers and gate windows go to zero, then a clearing
// pass over every word of the histogram memory (131072 words by default) zeroes the
// histograms; req.ready stays low until it ends.
`timescale 1ns / 1ps

module gated_matrix_slice_histogrammer #(
  parameter int NUM_GATES    = gmsh_pkg::NUM_GATES_DEF,
  parameter int NUM_CHANNELS = gmsh_pkg::NUM_CHANNELS_DEF
) (
  input logic       clk,
  input logic       rst,
  gmsh_req_if.sink  req,
  gmsh_rsp_if.source rsp,
  gmsh_cfg_if.sink  cfg
);

  gmsh_pkg::dp_cmd_t cmd;
  gmsh_pkg::dp_sts_t sts;

  assign cfg.ready = 1'b1;

  gmsh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gmsh_datapath #(
    .NUM_GATES    (NUM_GATES),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .req_type     (req.req_type),
    .gate_index   (req.gate_index),
    .gate_low     (req.gate_low),
    .gate_high    (req.gate_high),
    .cell_row     (req.cell_row),
    .cell_column  (req.cell_column),
    .cell_count   (req.cell_count),
    .read_channel (req.read_channel),
    .res_value    (rsp.read_value),
    .res_status   (rsp.status)
  );

endmodule

>>> rtl/gmsh_ctrl.sv
// Controller FSM of the gated matrix slice histogrammer.
// Depends on gmsh_pkg; drives datapath commands and the result valid flag.
`timescale 1ns / 1ps

module gmsh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gmsh_pkg::dp_cmd_t cmd,
  input  gmsh_pkg::dp_sts_t sts
);

  gmsh_pkg::state_t state, state_next;
  logic slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gmsh_pkg::ST_SWEEP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      gmsh_pkg::ST_SWEEP: begin
        cmd.sweep_write = 1'b1;
        if (sts.sweep_last) state_next = gmsh_pkg::ST_IDLE;
      end
      gmsh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_req = 1'b1;
          state_next   = gmsh_pkg::ST_DISPATCH;
        end
      end
      gmsh_pkg::ST_DISPATCH: begin
        priority if (sts.req_type == gmsh_pkg::REQ_LOAD) begin
          if (sts.gi_inactive) begin
            cmd.set_err = 1'b1;
            state_next  = gmsh_pkg::ST_FINISH;
          end else begin
            cmd.load_win = 1'b1;
            state_next   = gmsh_pkg::ST_CLEAR;
          end
        end else if (sts.req_type == gmsh_pkg::REQ_CELL) begin
          cmd.loop_all = 1'b1;
          state_next   = gmsh_pkg::ST_CELL_CHK;
        end else if (sts.req_type == gmsh_pkg::REQ_READ) begin
          if (sts.add_all) begin
            if (sts.ch_out) state_next = gmsh_pkg::ST_FINISH;
            else begin
              cmd.loop_all = 1'b1;
              state_next   = gmsh_pkg::ST_RD_CHK;
            end
          end else if (sts.gi_inactive) begin
            cmd.set_err = 1'b1;
            state_next  = gmsh_pkg::ST_FINISH;
          end else if (sts.ch_out) begin
            state_next = gmsh_pkg::ST_FINISH;
          end else begin
            cmd.loop_one = 1'b1;
            state_next   = gmsh_pkg::ST_RD_CHK;
          end
        end else begin
          state_next = gmsh_pkg::ST_FINISH;
        end
      end
      gmsh_pkg::ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_next = gmsh_pkg::ST_FINISH;
      end
      gmsh_pkg::ST_CELL_CHK: begin
        if (sts.loop_done) state_next = gmsh_pkg::ST_FINISH;
        else if (sts.hit) state_next = gmsh_pkg::ST_CELL_WR;
        else cmd.step_cell = 1'b1;
      end
      gmsh_pkg::ST_CELL_WR: begin
        cmd.bump_write = 1'b1;
        cmd.step_cell  = 1'b1;
        state_next     = gmsh_pkg::ST_CELL_CHK;
      end
      gmsh_pkg::ST_RD_CHK: begin
        if (sts.loop_done) state_next = gmsh_pkg::ST_FINISH;
        else state_next = gmsh_pkg::ST_RD_ACC;
      end
      gmsh_pkg::ST_RD_ACC: begin
        cmd.acc_add   = 1'b1;
        cmd.step_gate = 1'b1;
        state_next    = gmsh_pkg::ST_RD_CHK;
      end
      gmsh_pkg::ST_FINISH: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          state_next   = gmsh_pkg::ST_IDLE;
        end
      end
      default: state_next = gmsh_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/gmsh_datapath.sv
// Datapath of the gated matrix slice histogrammer: registers, gate windows,
// histogram memory, saturating update and summing. Depends on gmsh_pkg.
`timescale 1ns / 1ps

module gmsh_datapath #(
  parameter int NUM_GATES    = gmsh_pkg::NUM_GATES_DEF,
  parameter int NUM_CHANNELS = gmsh_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  gmsh_pkg::dp_cmd_t cmd,
  output gmsh_pkg::dp_sts_t sts,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [1:0]        req_type,
  input  logic [4:0]        gate_index,
  input  logic [11:0]       gate_low,
  input  logic [11:0]       gate_high,
  input  logic [11:0]       cell_row,
  input  logic [11:0]       cell_column,
  input  logic [31:0]       cell_count,
  input  logic [11:0]       read_channel,
  output logic [31:0]       res_value,
  output logic              res_status
);

  localparam int GW    = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
  localparam int CW    = $clog2(NUM_CHANNELS);
  localparam int AW    = GW + CW;
  localparam int DEPTH = 2 ** AW;
  localparam int GCW   = $clog2(NUM_GATES + 1);
  localparam int SW    = 33 + GCW;
  localparam logic [13:0] CH_LIM = 14'(NUM_CHANNELS);
  localparam logic [13:0] CLAMP  = 14'(NUM_CHANNELS - 1);
  localparam logic [CW-1:0] CLR_END = CW'(NUM_CHANNELS - 1);

  logic [1:0]  slice_mode;
  logic [5:0]  active_gates;
  logic        add_all;

  logic [1:0]  r_type;
  logic [4:0]  r_gi;
  logic [11:0] r_lo, r_hi, r_row, r_col, r_ch;
  logic [31:0] r_count;

  logic [11:0] win_lo [NUM_GATES];
  logic [11:0] win_hi [NUM_GATES];
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;

  logic [GCW-1:0] g, g_end, n_use;
  logic           phase, err;
  logic [CW-1:0]  clr_cnt;
  logic [AW-1:0]  sweep_cnt;
  logic [SW-1:0]  sum;

  logic [11:0]   a_min, a_max, c_lo, c_hi, key, bin, cur_lo, cur_hi;
  logic          gate_en, hit;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data, sat_bump, sat_sum;
  logic          we;
  logic [32:0]   bump;

  assign n_use = (7'(active_gates) > 7'(NUM_GATES)) ? GCW'(NUM_GATES) : GCW'(active_gates);

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_mode   <= '0;
      active_gates <= '0;
      add_all      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gmsh_pkg::CFG_SLICE_MODE:   slice_mode   <= cfg_data[1:0];
        gmsh_pkg::CFG_ACTIVE_GATES: active_gates <= cfg_data[5:0];
        gmsh_pkg::CFG_ADD_ALL:      add_all      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      r_type  <= req_type;
      r_gi    <= gate_index;
      r_lo    <= gate_low;
      r_hi    <= gate_high;
      r_row   <= cell_row;
      r_col   <= cell_column;
      r_count <= cell_count;
      r_ch    <= read_channel;
    end
  end

  // bounds ordered, then clamped to the channel range
  assign a_min = (r_lo > r_hi) ? r_hi : r_lo;
  assign a_max = (r_lo > r_hi) ? r_lo : r_hi;
  assign c_lo  = (14'(a_min) > CLAMP) ? 12'(CLAMP) : a_min;
  assign c_hi  = (14'(a_max) > CLAMP) ? 12'(CLAMP) : a_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GATES; i++) begin
        win_lo[i] <= '0;
        win_hi[i] <= '0;
      end
    end else if (cmd.load_win) begin
      win_lo[GW'(r_gi)] <= c_lo;
      win_hi[GW'(r_gi)] <= c_hi;
    end
  end

  // phase 0: gate on column, bin by row; phase 1: gate on row, bin by column
  assign cur_lo  = win_lo[GW'(g)];
  assign cur_hi  = win_hi[GW'(g)];
  assign key     = phase ? r_row : r_col;
  assign bin     = phase ? r_col : r_row;
  assign gate_en = phase ? (slice_mode != gmsh_pkg::MODE_Y) : (slice_mode != gmsh_pkg::MODE_X);
  assign hit     = gate_en && (key >= cur_lo) && (key <= cur_hi) && (14'(bin) < CH_LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      g       <= '0;
      g_end   <= '0;
      phase   <= 1'b0;
      err     <= 1'b0;
      clr_cnt <= '0;
      sweep_cnt <= '0;
      sum     <= '0;
    end else begin
      if (cmd.take_req) begin
        err     <= 1'b0;
        sum     <= '0;
        clr_cnt <= '0;
      end
      if (cmd.set_err) err <= 1'b1;
      if (cmd.sweep_write && !(&sweep_cnt)) sweep_cnt <= sweep_cnt + 1'b1;
      if (cmd.clr_write) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.loop_all) begin
        g     <= '0;
        g_end <= n_use;
        phase <= 1'b0;
      end
      if (cmd.loop_one) begin
        g     <= GCW'(r_gi);
        g_end <= GCW'(r_gi) + 1'b1;
        phase <= 1'b0;
      end
      if (cmd.step_cell) begin
        if (phase) begin
          phase <= 1'b0;
          g     <= g + 1'b1;
        end else begin
          phase <= 1'b1;
        end
      end
      if (cmd.step_gate) g <= g + 1'b1;
      if (cmd.acc_add) sum <= sum + {{(SW - 32){rdata[31]}}, rdata};
    end
  end

  assign bump     = {rdata[31], rdata} + {r_count[31], r_count};
  assign sat_bump = (bump[32] != bump[31]) ? (bump[32] ? gmsh_pkg::SAT_MIN : gmsh_pkg::SAT_MAX)
                                           : bump[31:0];
  assign sat_sum  = (sum[SW-1:31] == '0 || sum[SW-1:31] == '1) ? sum[31:0]
                  : (sum[SW-1] ? gmsh_pkg::SAT_MIN : gmsh_pkg::SAT_MAX);

  assign rd_addr = (r_type == gmsh_pkg::REQ_CELL) ? {GW'(g), CW'(bin)} : {GW'(g), CW'(r_ch)};

  always_comb begin
    we      = 1'b0;
    wr_addr = rd_addr;
    wr_data = sat_bump;
    priority if (cmd.sweep_write) begin
      we      = 1'b1;
      wr_addr = sweep_cnt;
      wr_data = '0;
    end else if (cmd.clr_write) begin
      we      = 1'b1;
      wr_addr = {GW'(r_gi), clr_cnt};
      wr_data = '0;
    end else if (cmd.bump_write) begin
      we = 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_value  <= sat_sum;
      res_status <= err;
    end
  end

  always_comb begin
    sts.gi_inactive = 7'(r_gi) >= 7'(n_use);
    sts.ch_out      = 14'(r_ch) >= CH_LIM;
    sts.loop_done   = g >= g_end;
    sts.hit         = hit;
    sts.clr_last    = clr_cnt == CLR_END;
    sts.sweep_last  = &sweep_cnt;
    sts.add_all     = add_all;
    sts.req_type    = r_type;
  end

endmodule

>>> rtl/gmsh_checker.sv
// Port-level assertions for the gated matrix slice histogrammer, bound to its top level.
// Depends on gated_matrix_slice_histogrammer.
`timescale 1ns / 1ps

module gmsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_status
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("result or request ready right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_value == 32'd0)
    else $error("error result carries a value");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind gated_matrix_slice_histogrammer gmsh_checker u_gmsh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_value  (rsp.read_value),
  .out_status (rsp.status)
);

>>> tb/sv/tb.sv
// Testbench for gated_matrix_slice_histogrammer: directed table, then random phases.
// Self-checking against an in-bench model of gates and histograms.
// Depends on gmsh_pkg, gmsh_if and the RTL top.
`timescale 1ns / 1ps

module tb;

  localparam int NG = 32;
  localparam int NCH = 4096;
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [1:0] MODE_SUM = 2'd2;
  localparam logic [1:0] MODE_ALT = 2'd3;
  localparam int WDOG_LIMIT = 400000;
  localparam int RAND_PER_PHASE = 200;

  typedef struct {
    logic [1:0]  kind;
    logic [4:0]  gi;
    logic [11:0] lo;
    logic [11:0] hi;
    logic [11:0] row;
    logic [11:0] col;
    logic [31:0] cnt;
    logic [11:0] ch;
    bit          fixed;
    logic [31:0] val;
    logic        st;
  } request_t;

  typedef struct {
    logic [31:0] val;
    logic        st;
  } outcome_t;

  logic clk = 0;
  logic rst = 1;
  always #1 clk = ~clk;

  gmsh_req_if req ();
  gmsh_rsp_if rsp ();
  gmsh_cfg_if cfg ();

  gated_matrix_slice_histogrammer u_top (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  logic [11:0] win_lo [NG];
  logic [11:0] win_hi [NG];
  logic signed [31:0] hist [NG*NCH];
  logic [1:0] mode_r;
  logic [5:0] active_r;
  logic       add_all_r;

  outcome_t expected_q[$];
  int errs = 0;
  bit quiet = 0;

  function automatic int gates_used();
    return active_r > NG ? NG : int'(active_r);
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void bump(int g, logic [11:0] bin, logic signed [31:0] c);
    int at;
    at = g * NCH + bin;
    hist[at] = sat32(longint'(hist[at]) + longint'(c));
  endfunction

  function automatic outcome_t histogram_step(request_t r);
    outcome_t o;
    int n;
    logic [11:0] a, b;
    longint sum;
    n = gates_used();
    o.val = 0;
    o.st = 0;
    case (r.kind)
      gmsh_pkg::REQ_LOAD: begin
        if (r.gi >= n) o.st = 1;
        else begin
          a = r.lo < r.hi ? r.lo : r.hi;
          b = r.lo < r.hi ? r.hi : r.lo;
          win_lo[r.gi] = a;
          win_hi[r.gi] = b;
          for (int i = 0; i < NCH; i++) hist[r.gi*NCH + i] = 0;
        end
      end
      gmsh_pkg::REQ_CELL: begin
        for (int g = 0; g < n; g++) begin
          if (mode_r != gmsh_pkg::MODE_X && r.col >= win_lo[g] && r.col <= win_hi[g])
            bump(g, r.row, r.cnt);
          if (mode_r != gmsh_pkg::MODE_Y && r.row >= win_lo[g] && r.row <= win_hi[g])
            bump(g, r.col, r.cnt);
        end
      end
      gmsh_pkg::REQ_READ: begin
        if (add_all_r) begin
          sum = 0;
          for (int g = 0; g < n; g++) sum += longint'(hist[g*NCH + r.ch]);
          o.val = sat32(sum);
        end else if (r.gi >= n) o.st = 1;
        else o.val = hist[r.gi*NCH + r.ch];
      end
      default: ;
    endcase
    return o;
  endfunction

  // response side: random stall bursts
  initial begin
    forever begin
      rsp.ready <= 1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet) begin
        rsp.ready <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: read_value %h status %0d", rsp.read_value, rsp.status);
        errs++;
      end else begin
        e = expected_q.pop_front();
        if (rsp.read_value !== e.val) begin
          $error("read_value expected %h actual %h", e.val, rsp.read_value);
          errs++;
        end
        if (rsp.status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, rsp.status);
          errs++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(request_t r);
    outcome_t o;
    int gap;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.req_type <= r.kind;
    req.gate_index <= r.gi;
    req.gate_low <= r.lo;
    req.gate_high <= r.hi;
    req.cell_row <= r.row;
    req.cell_column <= r.col;
    req.cell_count <= r.cnt;
    req.read_channel <= r.ch;
    do @(posedge clk); while (!req.ready);
    o = histogram_step(r);
    if (r.fixed) begin
      o.val = r.val;
      o.st = r.st;
    end
    expected_q.push_back(o);
  endtask

  task automatic drain();
    req.valid <= 0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] m, logic [31:0] a, logic [31:0] s);
    logic [31:0] vals [3];
    logic [7:0] idx [3];
    vals = '{m, a, s};
    idx = '{gmsh_pkg::CFG_SLICE_MODE, gmsh_pkg::CFG_ACTIVE_GATES, gmsh_pkg::CFG_ADD_ALL};
    for (int i = 0; i < 3; i++) begin
      cfg.valid <= 1;
      cfg.index <= idx[i];
      cfg.data <= vals[i];
      do @(posedge clk); while (!cfg.ready);
      case (idx[i])
        gmsh_pkg::CFG_SLICE_MODE: mode_r = vals[i][1:0];
        gmsh_pkg::CFG_ACTIVE_GATES: active_r = vals[i][5:0];
        default: add_all_r = vals[i][0];
      endcase
    end
    cfg.valid <= 0;
  endtask

  function automatic logic [11:0] pick_coord(int n);
    int g;
    if (n > 0 && $urandom_range(0, 9) < 7) begin
      g = $urandom_range(0, n - 1);
      return 12'($urandom_range(win_lo[g], win_hi[g]));
    end
    return 12'($urandom_range(0, NCH - 1));
  endfunction

  function automatic request_t random_request();
    request_t r;
    int n, k, w;
    n = gates_used();
    r.fixed = 0;
    r.val = 0;
    r.st = 0;
    k = $urandom_range(0, 99);
    r.kind = k < 4 ? gmsh_pkg::REQ_LOAD : k < 62 ? gmsh_pkg::REQ_CELL :
             k < 94 ? gmsh_pkg::REQ_READ : REQ_NONE;
    r.gi = (n > 0 && $urandom_range(0, 9) < 8) ? 5'($urandom_range(0, n - 1))
                                                : 5'($urandom);
    r.lo = 12'($urandom);
    r.hi = 12'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      w = $urandom_range(0, 40);
      r.hi = r.lo > NCH - 1 - w ? 12'(NCH - 1) : 12'(r.lo + w);
      if ($urandom_range(0, 1)) {r.lo, r.hi} = {r.hi, r.lo};
    end
    r.row = pick_coord(n);
    r.col = pick_coord(n);
    k = $urandom_range(0, 19);
    r.cnt = k < 14 ? 32'($urandom_range(0, 2000) - 1000) :
            k < 17 ? 32'($urandom) :
            k < 18 ? 32'h7fff_ffff : k < 19 ? 32'h8000_0000 : 32'hffff_ffff;
    r.ch = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? r.row : r.col)
                                : 12'($urandom);
    return r;
  endfunction

  request_t dir_tab [] = '{
    '{gmsh_pkg::REQ_READ, 5'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 12'd0,
      1, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_LOAD, 5'd5, 12'd1, 12'd2, 12'd0, 12'd0, 32'd0, 12'd0,
      1, 32'd0, 1'b1},
    '{gmsh_pkg::REQ_LOAD, 5'd0, 12'd100, 12'd50, 12'd0, 12'd0, 32'd0, 12'd0,
      1, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_LOAD, 5'd1, 12'd0, 12'd4095, 12'd0, 12'd0, 32'd0, 12'd0,
      1, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_LOAD, 5'd3, 12'd4095, 12'd4095, 12'd0, 12'd0, 32'd0, 12'd0,
      1, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_CELL, 5'd0, 12'd0, 12'd0, 12'd60, 12'd4095, 32'h7fff_ffff, 12'd0,
      1, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_CELL, 5'd0, 12'd0, 12'd0, 12'd60, 12'd4095, 32'h7fff_ffff, 12'd0,
      1, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_READ, 5'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 12'd4095,
      0, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_READ, 5'd1, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 12'd60,
      0, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_CELL, 5'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 32'h8000_0000, 12'd0,
      1, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_CELL, 5'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 32'h8000_0000, 12'd0,
      1, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_READ, 5'd3, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 12'd4095,
      0, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_READ, 5'd1, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 12'd4095,
      0, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_READ, 5'd31, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 12'd0,
      1, 32'd0, 1'b1},
    '{REQ_NONE, 5'd31, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hffff_ffff, 12'd4095,
      1, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_CELL, 5'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'hffff_ffff, 12'd0,
      1, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_READ, 5'd1, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 12'd0,
      0, 32'd0, 1'b0},
    '{gmsh_pkg::REQ_READ, 5'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 12'd75,
      0, 32'd0, 1'b0}
  };

  // per phase: slice_mode, active_gates, add_all
  int phase_cfg [8][3] = '{
    '{int'(gmsh_pkg::MODE_X), 1, 0}, '{int'(gmsh_pkg::MODE_Y), 32, 1},
    '{int'(MODE_ALT), 63, 0}, '{int'(gmsh_pkg::MODE_X), 0, 1},
    '{int'(MODE_SUM), 32, 0}, '{int'(gmsh_pkg::MODE_Y), 12, 0},
    '{int'(MODE_SUM), 7, 1}, '{int'(gmsh_pkg::MODE_X), 32, 1}
  };

  initial begin
    req.valid <= 0;
    req.req_type <= gmsh_pkg::REQ_LOAD;
    req.gate_index <= 0;
    req.gate_low <= 0;
    req.gate_high <= 0;
    req.cell_row <= 0;
    req.cell_column <= 0;
    req.cell_count <= 0;
    req.read_channel <= 0;
    cfg.valid <= 0;
    cfg.index <= 0;
    cfg.data <= 0;
    mode_r = 0;
    active_r = 0;
    add_all_r = 0;
    for (int g = 0; g < NG; g++) begin
      win_lo[g] = 0;
      win_hi[g] = 0;
    end
    for (int i = 0; i < NG*NCH; i++) hist[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_regs(32'(MODE_SUM), 32'd4, 32'd0);
    foreach (dir_tab[i]) send(dir_tab[i]);

    for (int p = 0; p < 8; p++) begin
      drain();
      if (p == 7) quiet = 1;
      write_regs(phase_cfg[p][0] | ($urandom & 32'hffff_fffc),
                 phase_cfg[p][1] | ($urandom & 32'hffff_ffc0),
                 phase_cfg[p][2] | ($urandom & 32'hffff_fffe));
      for (int i = 0; i < RAND_PER_PHASE; i++) send(random_request());
    end

    req.valid <= 0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (20) @(posedge clk);
    if (errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> gated_matrix_slice_histogrammer.f
rtl/gmsh_pkg.sv
rtl/gmsh_if.sv
rtl/gmsh_ctrl.sv
rtl/gmsh_datapath.sv
rtl/gated_matrix_slice_histogrammer.sv
rtl/gmsh_checker.sv
tb/sv/tb.sv
